FILE: rtl/core/jeop_pkg.sv
// Shared types and constants for the JPEG Exif orientation parser.
package jeop_pkg;

  // Byte buffer geometry.
  localparam int BUF_BYTES = 65536;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);

  // Width of the shared adder and comparator; holds any position or offset sum.
  localparam int ALU_W = 34;

  // Marker codes.
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_APP1   = 8'hE1;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST_LO = 8'hD0;
  localparam logic [7:0] MK_RST_HI = 8'hD7;

  // Exif and TIFF header codes.
  localparam logic [31:0] EXIF_ID      = 32'h45786966;
  localparam logic [15:0] ORDER_MM     = 16'h4D4D;
  localparam logic [15:0] ORDER_II     = 16'h4949;
  localparam logic [15:0] TAG_ORIENT   = 16'h0112;
  localparam logic [15:0] APP1_MIN_LEN = 16'd16;
  localparam logic [15:0] APP1_HDR_LEN = 16'd8;
  localparam int          ENTRY_BYTES  = 12;

  // One input request: a file byte and the end-of-file mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  // One result.
  typedef struct packed {
    logic [15:0] orientation;
    logic        overflow;
  } result_t;

  // Sequencer to buffer controls.
  typedef struct packed {
    logic              clr;
    logic [ADDR_W-1:0] raddr;
  } buf_ctl_t;

  // Buffer status seen by the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             dropped;
    logic [7:0]       q;
  } buf_sts_t;

endpackage

FILE: rtl/core/jeop_buf.sv
// Byte buffer: file byte memory with fill count and drop flag.
module jeop_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  logic [7:0]         wdata,
  input  jeop_pkg::buf_ctl_t ctl,
  output jeop_pkg::buf_sts_t sts
);

  logic [7:0]                 mem [jeop_pkg::BUF_BYTES];
  logic [jeop_pkg::CNT_W-1:0] count;
  logic                       dropped;
  logic [7:0]                 q;
  logic                       full;

  assign full = (count == jeop_pkg::CNT_W'(jeop_pkg::BUF_BYTES));

  // Store the byte at the fill position while there is room.
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[count[jeop_pkg::ADDR_W-1:0]] <= wdata;
    end
    q <= mem[ctl.raddr];
  end

  // Fill count and drop flag; cleared when a result goes out.
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (wr) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  assign sts.count   = count;
  assign sts.dropped = dropped;
  assign sts.q       = q;

endmodule

FILE: rtl/core/jeop_alu.sv
// Shared adder with unsigned compare of the sum against a bound.
module jeop_alu (
  input  logic [jeop_pkg::ALU_W-1:0] a,
  input  logic [jeop_pkg::ALU_W-1:0] b,
  input  logic [jeop_pkg::ALU_W-1:0] c,
  output logic [jeop_pkg::ALU_W-1:0] sum,
  output logic                       gt,
  output logic                       lt
);

  // One add, then both orderings against the bound.
  assign sum = a + b;
  assign gt  = (sum > c);
  assign lt  = (sum < c);

endmodule

FILE: rtl/core/jeop_seq.sv
// Parse sequencer: walks the buffered file through the shared adder.
module jeop_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  jeop_pkg::buf_sts_t sts,
  output jeop_pkg::buf_ctl_t ctl,
  output logic               busy,
  output logic               done,
  output jeop_pkg::result_t  result
);

  localparam int AW = jeop_pkg::ALU_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHKN  = 5'd1;
  localparam logic [4:0] S_LDA   = 5'd2;
  localparam logic [4:0] S_LDD   = 5'd3;
  localparam logic [4:0] S_SOI   = 5'd4;
  localparam logic [4:0] S_WALK  = 5'd5;
  localparam logic [4:0] S_MARK  = 5'd6;
  localparam logic [4:0] S_SKIP  = 5'd7;
  localparam logic [4:0] S_E1A   = 5'd8;
  localparam logic [4:0] S_E1B   = 5'd9;
  localparam logic [4:0] S_HDR1  = 5'd10;
  localparam logic [4:0] S_HDR2  = 5'd11;
  localparam logic [4:0] S_HDR3  = 5'd12;
  localparam logic [4:0] S_OFF   = 5'd13;
  localparam logic [4:0] S_TIFF  = 5'd14;
  localparam logic [4:0] S_IFD   = 5'd15;
  localparam logic [4:0] S_CNT   = 5'd16;
  localparam logic [4:0] S_ENT   = 5'd17;
  localparam logic [4:0] S_TAG   = 5'd18;
  localparam logic [4:0] S_VAL   = 5'd19;
  localparam logic [4:0] S_NEXT1 = 5'd20;
  localparam logic [4:0] S_NEXT2 = 5'd21;
  localparam logic [4:0] S_FIN   = 5'd22;

  logic [4:0]    state;
  logic [4:0]    ret;
  logic [AW-1:0] ld_addr;
  logic [3:0]    ld_left;
  logic [31:0]   sh;
  logic [AW-1:0] pos;
  logic [AW-1:0] ex;
  logic [AW-1:0] base;
  logic [AW-1:0] bound;
  logic [AW-1:0] eaddr;
  logic [31:0]   off;
  logic [15:0]   seg;
  logic [15:0]   tsize;
  logic [15:0]   cnt;
  logic [15:0]   idx;
  logic          big;
  logic [15:0]   res_val;

  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic [AW-1:0] alu_c;
  logic [AW-1:0] alu_sum;
  logic          alu_gt;
  logic          alu_lt;

  logic [15:0]   rd16;
  logic [31:0]   rd32;
  logic [7:0]    mk;

  // Field assembly from the byte shift register in the file's byte order.
  assign rd16 = big ? sh[15:0] : {sh[7:0], sh[15:8]};
  assign rd32 = big ? sh : {sh[7:0], sh[15:8], sh[23:16], sh[31:24]};
  assign mk   = sh[23:16];

  jeop_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .sum (alu_sum),
    .gt  (alu_gt),
    .lt  (alu_lt)
  );

  // Operand selection for the shared adder, one use per state.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    case (state)
      S_CHKN: begin
        alu_a = AW'(4);
        alu_c = AW'(sts.count);
      end
      S_WALK: begin
        alu_a = pos;
        alu_b = AW'(4);
        alu_c = AW'(sts.count);
      end
      S_MARK, S_E1A: begin
        alu_a = pos;
        alu_b = AW'(2);
      end
      S_SKIP: begin
        alu_a = pos;
        alu_b = AW'(seg);
      end
      S_E1B: begin
        alu_a = ex;
        alu_b = AW'(seg);
        alu_c = AW'(sts.count);
      end
      S_OFF: begin
        alu_a = AW'(rd32);
        alu_b = AW'(2);
        alu_c = AW'(tsize);
      end
      S_TIFF: begin
        alu_a = ex;
        alu_b = AW'(6);
      end
      S_IFD: begin
        alu_a = base;
        alu_b = AW'(off);
      end
      S_CNT: begin
        alu_a = AW'(off);
        alu_b = AW'(2);
      end
      S_ENT, S_NEXT1: begin
        alu_a = bound;
        alu_b = AW'(jeop_pkg::ENTRY_BYTES);
        alu_c = AW'(tsize);
      end
      S_NEXT2: begin
        alu_a = eaddr;
        alu_b = AW'(jeop_pkg::ENTRY_BYTES);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // Control state of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go) begin
            state <= S_CHKN;
          end
        end
        S_CHKN: begin
          if (alu_gt) begin
            state <= S_FIN;
          end else begin
            state <= S_LDA;
          end
        end
        S_LDA: begin
          state <= S_LDD;
        end
        S_LDD: begin
          if (ld_left == 4'd1) begin
            state <= ret;
          end else begin
            state <= S_LDA;
          end
        end
        S_SOI: begin
          if (sh[15:0] == {jeop_pkg::MK_PREFIX, jeop_pkg::MK_SOI}) begin
            state <= S_WALK;
          end else begin
            state <= S_FIN;
          end
        end
        S_WALK: begin
          state <= alu_lt ? S_LDA : S_FIN;
        end
        S_MARK: begin
          if (sh[31:24] != jeop_pkg::MK_PREFIX || mk == jeop_pkg::MK_SOS) begin
            state <= S_FIN;
          end else if (mk inside {jeop_pkg::MK_TEM,
                                  [jeop_pkg::MK_RST_LO:jeop_pkg::MK_RST_HI]}) begin
            state <= S_WALK;
          end else if (mk == jeop_pkg::MK_APP1) begin
            state <= S_E1A;
          end else begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          state <= S_WALK;
        end
        S_E1A: begin
          state <= S_E1B;
        end
        S_E1B: begin
          if (alu_gt || seg < jeop_pkg::APP1_MIN_LEN) begin
            state <= S_FIN;
          end else begin
            state <= S_LDA;
          end
        end
        S_HDR1: begin
          state <= (sh == jeop_pkg::EXIF_ID) ? S_LDA : S_FIN;
        end
        S_HDR2: begin
          if (sh[31:16] == 16'h0000 &&
              (sh[15:0] == jeop_pkg::ORDER_MM || sh[15:0] == jeop_pkg::ORDER_II)) begin
            state <= S_LDA;
          end else begin
            state <= S_FIN;
          end
        end
        S_HDR3: begin
          state <= S_LDA;
        end
        S_OFF: begin
          state <= alu_gt ? S_FIN : S_TIFF;
        end
        S_TIFF: begin
          state <= S_IFD;
        end
        S_IFD: begin
          state <= S_LDA;
        end
        S_CNT: begin
          state <= S_ENT;
        end
        S_ENT: begin
          if (idx == cnt || alu_gt) begin
            state <= S_FIN;
          end else begin
            state <= S_LDA;
          end
        end
        S_TAG: begin
          state <= (rd16 == jeop_pkg::TAG_ORIENT) ? S_LDA : S_NEXT1;
        end
        S_VAL: begin
          state <= S_FIN;
        end
        S_NEXT1: begin
          state <= S_NEXT2;
        end
        S_NEXT2: begin
          state <= S_ENT;
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: byte loads, positions, offsets and the answer.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_val <= '0;
        big     <= 1'b1;
      end
      S_CHKN: begin
        ld_addr <= '0;
        ld_left <= 4'd2;
        ret     <= S_SOI;
      end
      S_LDD: begin
        sh      <= {sh[23:0], sts.q};
        ld_addr <= ld_addr + 1'b1;
        ld_left <= ld_left - 1'b1;
      end
      S_SOI: begin
        pos <= AW'(2);
      end
      S_WALK: begin
        ld_addr <= pos;
        ld_left <= 4'd4;
        ret     <= S_MARK;
      end
      S_MARK: begin
        pos <= alu_sum;
        seg <= sh[15:0];
      end
      S_SKIP: begin
        pos <= alu_sum;
      end
      S_E1A: begin
        ex <= alu_sum;
      end
      S_E1B: begin
        tsize   <= seg - jeop_pkg::APP1_HDR_LEN;
        ld_addr <= ex;
        ld_left <= 4'd4;
        ret     <= S_HDR1;
      end
      S_HDR1: begin
        ld_left <= 4'd4;
        ret     <= S_HDR2;
      end
      S_HDR2: begin
        big     <= (sh[15:0] == jeop_pkg::ORDER_MM);
        ld_left <= 4'd2;
        ret     <= S_HDR3;
      end
      S_HDR3: begin
        ld_left <= 4'd4;
        ret     <= S_OFF;
      end
      S_OFF: begin
        off <= rd32;
      end
      S_TIFF: begin
        base <= alu_sum;
      end
      S_IFD: begin
        ld_addr <= alu_sum;
        ld_left <= 4'd2;
        ret     <= S_CNT;
      end
      S_CNT: begin
        cnt   <= rd16;
        bound <= alu_sum;
        eaddr <= ld_addr;
        idx   <= '0;
      end
      S_ENT: begin
        ld_addr <= eaddr;
        ld_left <= 4'd2;
        ret     <= S_TAG;
      end
      S_TAG: begin
        ld_left <= 4'd8;
        ret     <= S_VAL;
      end
      S_VAL: begin
        res_val <= rd16;
      end
      S_NEXT1: begin
        bound <= alu_sum;
        idx   <= idx + 1'b1;
      end
      S_NEXT2: begin
        eaddr <= alu_sum;
      end
      S_FIN: begin
        result.orientation <= res_val;
        result.overflow    <= sts.dropped;
      end
      default: begin
        ld_left <= ld_left;
      end
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign ctl.raddr = ld_addr[jeop_pkg::ADDR_W-1:0];
  assign ctl.clr   = (state == S_FIN);

endmodule

FILE: rtl/core/jpeg_exif_orientation_parser_top.sv
// Top level of the JPEG Exif orientation parser.
//
//  Channel   Direction  Handshake             Payload
//  request   in         start high, busy low  item: data_byte, last
//  result    out        done, one cycle       result: orientation, overflow
//
// Bytes load at one per cycle; busy stays low until the byte marked last.
// The parse then reads the buffer a byte at a time through one read port, with
// the shared adder stepping positions, so its length grows with the number of
// segments walked and IFD entries searched. done pulses in the cycle busy drops.
// Reset is synchronous and clears the control state, fill count and drop flag.
// The receiver cannot stall; done is never held.
module jpeg_exif_orientation_parser_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  jeop_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output jeop_pkg::result_t result
);

  logic               accept;
  jeop_pkg::buf_ctl_t ctl;
  jeop_pkg::buf_sts_t sts;

  // A request is taken whenever the parser is not busy.
  assign accept = start && !busy;

  jeop_buf u_buf (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept),
    .wdata (item.data_byte),
    .ctl   (ctl),
    .sts   (sts)
  );

  jeop_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .go     (accept && item.last),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

endmodule

FILE: rtl/core/jeop_checker.sv
// Port-level checker for the parser top level, with its bind.
module jeop_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input jeop_pkg::item_t item,
  input logic            busy,
  input logic            done
);

  // A result appears only once the parser has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  // A byte that is not the last keeps the block ready for the next one.
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.last) |=> !busy) else $error("busy while loading");

  // The last byte starts a parse.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last) |=> busy) else $error("parse did not start");

  // A parse always ends with a result.
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done) else $error("parse ended without result");

endmodule

bind jpeg_exif_orientation_parser_top jeop_checker u_jeop_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .item  (item),
  .busy  (busy),
  .done  (done)
);

FILE: dv/jeop_orientation_checker.sv
// Result checker for the JPEG Exif orientation parser: predicts each result and compares.
module jeop_orientation_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  jeop_pkg::item_t     item,
  input  logic                done,
  input  jeop_pkg::result_t   result,
  output int unsigned         mismatch_count,
  output int unsigned         waiting_count,
  output int unsigned         checked_count
);
  import jeop_pkg::*;

  // Local copy of the file buffer and its fill state.
  logic [7:0]  file_mem [BUF_BYTES];
  int unsigned held_bytes;
  bit          bytes_lost;

  // Results owed by the block, oldest first.
  result_t     orient_expect_q [$];
  result_t     oldest;
  int unsigned errors;
  int unsigned checked;

  function automatic logic [15:0] rd16(input longint unsigned at, input bit big);
    logic [7:0] a;
    logic [7:0] b;
    a = file_mem[at];
    b = file_mem[at + 1];
    return big ? {a, b} : {b, a};
  endfunction

  function automatic logic [31:0] rd32(input longint unsigned at, input bit big);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = rd16(at, big);
    lo = rd16(at + 2, big);
    return big ? {hi, lo} : {lo, hi};
  endfunction

  // Walks the buffered file the way the block does and returns the orientation.
  function automatic logic [15:0] predict_orientation();
    longint unsigned n, pos, seg, ex, tiff, tsize, off, ifd, ep, i;
    logic [7:0]      mk;
    logic [15:0]     order;
    logic [15:0]     cnt;
    bit              big;
    n   = held_bytes;
    pos = 2;
    if (n < 4 || file_mem[0] != MK_PREFIX || file_mem[1] != MK_SOI) return 16'h0000;
    while (pos + 4 < n) begin
      if (file_mem[pos] != MK_PREFIX) return 16'h0000;
      mk = file_mem[pos + 1];
      if (mk == MK_SOS) return 16'h0000;
      // Standalone markers carry no length.
      if (mk == MK_TEM || (mk >= MK_RST_LO && mk <= MK_RST_HI)) begin
        pos += 2;
        continue;
      end
      seg = {file_mem[pos + 2], file_mem[pos + 3]};
      if (mk == MK_APP1) begin
        ex = pos + 4;
        if (ex + seg > n) return 16'h0000;
        if (seg < 11) return 16'h0000;
        if ({file_mem[ex], file_mem[ex + 1], file_mem[ex + 2], file_mem[ex + 3]} != EXIF_ID ||
            file_mem[ex + 4] != 8'h00 || file_mem[ex + 5] != 8'h00) return 16'h0000;
        tiff  = ex + 6;
        tsize = seg - 8;
        if (tsize < 8) return 16'h0000;
        order = {file_mem[tiff], file_mem[tiff + 1]};
        if (order == ORDER_MM) begin
          big = 1'b1;
        end else if (order == ORDER_II) begin
          big = 1'b0;
        end else begin
          return 16'h0000;
        end
        off = rd32(tiff + 4, big);
        if (off + 2 > tsize) return 16'h0000;
        ifd = tiff + off;
        cnt = rd16(ifd, big);
        // Search the first IFD; an entry that runs past the TIFF data ends it.
        for (i = 0; i < cnt; i++) begin
          ep = 2 + i * ENTRY_BYTES;
          if (off + ep + ENTRY_BYTES > tsize) return 16'h0000;
          if (rd16(ifd + ep, big) == TAG_ORIENT) return rd16(ifd + ep + 8, big);
        end
        return 16'h0000;
      end
      pos += 2 + seg;
    end
    return 16'h0000;
  endfunction

  // Results are compared before the request of the same edge is taken in.
  always @(posedge clk) begin
    if (rst) begin
      held_bytes = 0;
      bytes_lost = 0;
      orient_expect_q.delete();
    end else begin
      if (done) begin
        if (orient_expect_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: unexpected result orientation %h overflow %b",
                     result.orientation, result.overflow);
        end else begin
          oldest = orient_expect_q.pop_front();
          checked++;
          if (result.orientation !== oldest.orientation ||
              result.overflow !== oldest.overflow) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: orientation exp %h got %h, overflow exp %b got %b",
                       oldest.orientation, result.orientation,
                       oldest.overflow, result.overflow);
          end
        end
      end
      if (start && !busy) begin
        // A full buffer drops the byte but remembers that it did.
        if (held_bytes < BUF_BYTES) begin
          file_mem[held_bytes] = item.data_byte;
          held_bytes++;
        end else begin
          bytes_lost = 1'b1;
        end
        if (item.last) begin
          orient_expect_q.push_back('{orientation: predict_orientation(),
                                      overflow: bytes_lost});
          held_bytes = 0;
          bytes_lost = 0;
        end
      end
    end
    mismatch_count <= errors;
    waiting_count  <= orient_expect_q.size();
    checked_count  <= checked;
  end

endmodule

FILE: dv/jpeg_exif_orientation_parser_top_tb.sv
// Testbench top for the JPEG Exif orientation parser: builds files, drives bytes, gives the verdict.
module jpeg_exif_orientation_parser_top_tb;
  import jeop_pkg::*;

  // Marker and TIFF codes used only to build files.
  localparam logic [7:0]  MK_APP0        = 8'hE0;
  localparam logic [7:0]  MK_DQT         = 8'hDB;
  localparam logic [7:0]  MK_DHT         = 8'hC4;
  localparam logic [7:0]  MK_COM         = 8'hFE;
  localparam logic [7:0]  MK_EOI         = 8'hD9;
  localparam logic [15:0] TIFF_MAGIC     = 16'h002A;
  localparam logic [15:0] TAG_TYPE_SHORT = 16'h0003;

  localparam int QUIET_LIMIT = 100000;
  localparam int TAIL_CYCLES = 64;

  // Ways a generated file is damaged.
  typedef enum int {
    FLAW_NONE, FLAW_BYTE, FLAW_LEN, FLAW_CUT, FLAW_OFFSET, FLAW_COUNT, FLAW_ORDER
  } flaw_e;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;

  int unsigned mismatch_count;
  int unsigned waiting_count;
  int unsigned checked_count;

  logic [7:0]  fbytes [$];
  bit          idle_on;
  int unsigned files_sent;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;

  jpeg_exif_orientation_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  jeop_orientation_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (item),
    .done           (done),
    .result         (result),
    .mismatch_count (mismatch_count),
    .waiting_count  (waiting_count),
    .checked_count  (checked_count)
  );

  always #6 clk = ~clk;

  // Watchdog: ends the run when neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic put8(input logic [7:0] b);
    fbytes.push_back(b);
  endtask

  task automatic put16(input logic [15:0] v, input bit big);
    if (big) begin
      put8(v[15:8]);
      put8(v[7:0]);
    end else begin
      put8(v[7:0]);
      put8(v[15:8]);
    end
  endtask

  task automatic put32(input logic [31:0] v, input bit big);
    if (big) begin
      put16(v[31:16], big);
      put16(v[15:0], big);
    end else begin
      put16(v[15:0], big);
      put16(v[31:16], big);
    end
  endtask

  // Appends an APP1 Exif segment with one IFD, damaged as a length, offset, count or order flaw says.
  task automatic add_app1(input flaw_e flaw);
    bit          big;
    int          n_ent, hit, pad, tiff_len, seg_len, k;
    logic [15:0] val;
    logic [31:0] off;
    big      = 1'($urandom_range(0, 1));
    n_ent    = $urandom_range(0, 5);
    hit      = $urandom_range(0, n_ent);
    pad      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    off      = 8 + pad;
    tiff_len = 8 + pad + 2 + ENTRY_BYTES * n_ent + 4;
    seg_len  = 8 + tiff_len;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: val = 16'($urandom_range(1, 8));
      4, 5:       val = 16'($urandom);
      6:          val = 16'hFFFF;
      default:    val = 16'h0000;
    endcase
    if (flaw == FLAW_LEN) seg_len = seg_len + $urandom_range(0, 24) - 12;
    if (flaw == FLAW_OFFSET) off = $urandom_range(0, 1) ? $urandom : tiff_len - $urandom_range(0, 3);
    put8(MK_PREFIX);
    put8(MK_APP1);
    put16(16'(seg_len), 1'b1);
    put32(EXIF_ID, 1'b1);
    put16(16'h0000, 1'b1);
    if (flaw == FLAW_ORDER) begin
      put16(16'($urandom), 1'b1);
    end else begin
      put16(big ? ORDER_MM : ORDER_II, 1'b1);
    end
    put16(TIFF_MAGIC, big);
    put32(off, big);
    repeat (pad) put8(8'($urandom));
    put16(16'(n_ent + ((flaw == FLAW_COUNT) ? $urandom_range(1, 3) : 0)), big);
    for (k = 0; k < n_ent; k++) begin
      put16((k == hit) ? TAG_ORIENT : 16'($urandom), big);
      put16(TAG_TYPE_SHORT, big);
      put32(32'd1, big);
      put16((k == hit) ? val : 16'($urandom), big);
      put16(16'h0000, big);
    end
    put32(32'd0, big);
  endtask

  // Builds a JPEG-like file: leading segments, usually an Exif block, then usually a tail.
  task automatic make_jpeg(input flaw_e flaw);
    int         n_pre, len, cut, k;
    logic [7:0] mk;
    fbytes.delete();
    put8(MK_PREFIX);
    put8(MK_SOI);
    n_pre = $urandom_range(0, 3);
    for (k = 0; k < n_pre; k++) begin
      if ($urandom_range(0, 2) == 0) begin
        put8(MK_PREFIX);
        put8($urandom_range(0, 1) ? MK_TEM : 8'(MK_RST_LO + $urandom_range(0, 7)));
      end else begin
        case ($urandom_range(0, 3))
          0:       mk = MK_APP0;
          1:       mk = MK_DQT;
          2:       mk = MK_DHT;
          default: mk = MK_COM;
        endcase
        len = $urandom_range(2, 10);
        put8(MK_PREFIX);
        put8(mk);
        put16(16'(len), 1'b1);
        repeat (len - 2) put8(8'($urandom));
      end
    end
    if ($urandom_range(0, 9) != 0) add_app1(flaw);
    if ($urandom_range(0, 1)) begin
      put8(MK_PREFIX);
      put8(MK_SOS);
      repeat ($urandom_range(0, 4)) put8(8'($urandom));
    end else if ($urandom_range(0, 1)) begin
      put8(MK_PREFIX);
      put8(MK_EOI);
    end
    // Damage after the fact: one corrupted byte, or a cut-off file.
    if (flaw == FLAW_BYTE) fbytes[$urandom_range(0, fbytes.size() - 1)] = 8'($urandom);
    if (flaw == FLAW_CUT) begin
      cut = $urandom_range(1, fbytes.size());
      while (fbytes.size() > cut) void'(fbytes.pop_back());
    end
  endtask

  // Short random data, sometimes with a valid start marker.
  task automatic make_noise();
    int len;
    fbytes.delete();
    len = $urandom_range(1, 40);
    if (len >= 2 && $urandom_range(0, 1)) begin
      put8(MK_PREFIX);
      put8(MK_SOI);
    end
    while (fbytes.size() < len) put8(($urandom_range(0, 3) == 0) ? MK_PREFIX : 8'($urandom));
  endtask

  // Offers one request and returns at the edge that accepts it.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 6) begin
        start <= 1'b0;
        item  <= item_t'(9'($urandom_range(0, 511)));
        @(posedge clk);
      end
    end
    start <= 1'b1;
    item  <= '{data_byte: b, last: is_last};
    do @(posedge clk); while (busy);
  endtask

  task automatic send_file();
    int k;
    for (k = 0; k < fbytes.size(); k++) send_byte(fbytes[k], k == fbytes.size() - 1);
    files_sent++;
    bytes_sent += fbytes.size();
  endtask

  // Holds the sender off until every owed result has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned pick;
    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    idle_on      = 1'b1;
    files_sent   = 0;
    bytes_sent   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Degenerate files: single bytes, too short, bad start, scan start, standalone markers.
    fbytes.delete(); put8(8'h00); send_file();
    fbytes.delete(); put8(8'hFF); send_file();
    fbytes.delete(); put8(MK_PREFIX); put8(MK_SOI); put8(MK_PREFIX); send_file();
    fbytes.delete(); put8(MK_PREFIX); put8(MK_SOI); put8(MK_PREFIX); put8(MK_EOI); send_file();
    fbytes.delete(); put8(MK_PREFIX); put8(8'h00); put8(8'h55); put8(8'hAA); send_file();
    fbytes.delete();
    put8(MK_PREFIX); put8(MK_SOI); put8(MK_PREFIX); put8(MK_SOS); put8(8'h00);
    send_file();
    fbytes.delete();
    put8(MK_PREFIX); put8(MK_SOI); put8(MK_PREFIX); put8(MK_RST_HI);
    put8(MK_PREFIX); put8(MK_TEM); put8(8'h00); put8(8'h00); put8(8'h00);
    send_file();
    wait_drained();

    // Random files, mostly well formed; a middle stretch runs without sender gaps.
    while (bytes_sent < 1400) begin
      idle_on = !(files_sent >= 10 && files_sent < 22);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        make_jpeg(FLAW_NONE);
      end else if (pick < 80) begin
        make_jpeg(flaw_e'($urandom_range(1, 6)));
      end else begin
        make_noise();
      end
      send_file();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d files, %0d bytes sent, %0d results checked, %0d mismatches",
             files_sent, bytes_sent, checked_count, mismatch_count);
    $display("summary: short, noise, damaged and Exif files in both byte orders");
    if (mismatch_count == 0 && waiting_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
